// ===== sv/i2a_pkg.sv =====
// Shared types, codes and character helpers for the integer to ASCII formatter.
package i2a_pkg;

   // Default operand width and digit buffer sizing
   localparam int WORD_BITS_DEF = 64;
   localparam int NUM_DIGITS    = 22;   // octal text of a 64-bit word
   localparam int DEC_DIGITS    = 20;   // decimal text of a 64-bit word
   localparam int NARROW_BITS   = 32;

   // Conversion modes
   localparam logic [2:0] MODE_SDEC = 3'd0;
   localparam logic [2:0] MODE_UDEC = 3'd1;
   localparam logic [2:0] MODE_HEXL = 3'd2;
   localparam logic [2:0] MODE_HEXU = 3'd3;
   localparam logic [2:0] MODE_OCT  = 3'd4;
   localparam logic [2:0] MODE_PTR  = 3'd5;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] DIGIT_TEN    = 8'd10;

   // What the datapath drives onto the result ports in a cycle
   typedef enum logic [2:0] {
      EMIT_NONE  = 3'd0,
      EMIT_DIGIT = 3'd1,
      EMIT_MINUS = 3'd2,
      EMIT_ZERO  = 3'd3,
      EMIT_X     = 3'd4
   } emit_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic         load;
      logic         dabble;
      logic         skip;
      emit_sel_type emit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic neg;
      logic top_zero;
      logic cnt_one;
   } dp_status_type;

   // One digit (0..15) to its ASCII character
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = CHAR_ZERO + {4'h0, d};
      end else if (upper) begin
         r = CHAR_UPPER_A + {4'h0, d} - DIGIT_TEN;
      end else begin
         r = CHAR_LOWER_A + {4'h0, d} - DIGIT_TEN;
      end
      return r;
   endfunction

endpackage

// ===== sv/i2a_dpath.sv =====
// Datapath: operand load, shift-add-3 BCD conversion, digit buffer and output word register.
module i2a_dpath
   import i2a_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [63:0]          req_value,
   input  logic [2:0]           req_mode,
   input  logic                 req_wide,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   output logic [7:0]           rsp_char_code,
   output logic                 rsp_last,
   output logic                 rsp_strobe
);

   localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
   localparam int OCT_DIGITS = (WORD_BITS + 2) / 3;
   localparam int HEX_VBITS  = 4 * NUM_DIGITS;
   localparam int OCT_VBITS  = 3 * NUM_DIGITS;
   localparam int CNT_BITS   = $clog2(NUM_DIGITS + 1);

   logic [3:0]           digs_ff [NUM_DIGITS];
   logic [3:0]           digs_in [NUM_DIGITS];
   logic [3:0]           adj     [DEC_DIGITS];
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic                 upper_ff, upper_in;
   logic [7:0]           char_ff, char_in;
   logic                 last_ff, last_in;
   logic                 strobe_ff, strobe_in;

   logic [WORD_BITS-1:0] opnd, negated, mag_ld;
   logic                 sign_bit, neg_ld;
   logic [HEX_VBITS-1:0] hex_vec;
   logic [OCT_VBITS-1:0] oct_vec;

   // Operand extension and two's-complement magnitude
   always_comb begin
      if (req_wide || req_mode == MODE_PTR) begin
         opnd = req_value[WORD_BITS-1:0];
      end else begin
         opnd = WORD_BITS'(req_value[NARROW_BITS-1:0]);
      end
      sign_bit = req_wide ? opnd[WORD_BITS-1] : opnd[NARROW_BITS-1];
      neg_ld   = (req_mode == MODE_SDEC) && sign_bit;
      negated  = '0 - opnd;
      if (!req_wide) begin
         negated = WORD_BITS'(negated[NARROW_BITS-1:0]);
      end
      mag_ld  = neg_ld ? negated : opnd;
      // left-justify the digit groups so digit 0 is the most significant
      hex_vec = HEX_VBITS'(mag_ld) << (4 * (NUM_DIGITS - HEX_DIGITS));
      oct_vec = OCT_VBITS'(mag_ld) << (3 * (NUM_DIGITS - OCT_DIGITS));
   end

   // BCD digit adjust ahead of each shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         adj[i] = (digs_ff[i] >= 4'd5) ? digs_ff[i] + 4'd3 : digs_ff[i];
      end
   end

   // Next state of the digit buffer and operand
   always_comb begin
      digs_in  = digs_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      upper_in = upper_ff;
      if (cmd.load) begin
         neg_in   = neg_ld;
         upper_in = (req_mode == MODE_HEXU);
         mag_in   = req_wide ? mag_ld : mag_ld << (WORD_BITS - NARROW_BITS);
         case (req_mode) inside
            MODE_HEXL, MODE_HEXU, MODE_PTR: begin
               cnt_in = CNT_BITS'(HEX_DIGITS);
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  digs_in[i] = hex_vec[4 * (NUM_DIGITS - 1 - i) +: 4];
               end
            end
            MODE_OCT: begin
               cnt_in = CNT_BITS'(OCT_DIGITS);
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  digs_in[i] = {1'b0, oct_vec[3 * (NUM_DIGITS - 1 - i) +: 3]};
               end
            end
            default: begin
               cnt_in = CNT_BITS'(DEC_DIGITS);
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  digs_in[i] = 4'h0;
               end
            end
         endcase
      end else if (cmd.dabble) begin
         // shift the BCD string left one bit, operand msb enters at the bottom
         for (int i = 0; i < DEC_DIGITS - 1; i++) begin
            digs_in[i] = {adj[i][2:0], adj[i+1][3]};
         end
         digs_in[DEC_DIGITS-1] = {adj[DEC_DIGITS-1][2:0], mag_ff[WORD_BITS-1]};
         mag_in = mag_ff << 1;
      end else if (cmd.skip || cmd.emit == EMIT_DIGIT) begin
         for (int i = 0; i < NUM_DIGITS - 1; i++) begin
            digs_in[i] = digs_ff[i+1];
         end
         digs_in[NUM_DIGITS-1] = 4'h0;
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
   end

   // Output word
   always_comb begin
      strobe_in = (cmd.emit != EMIT_NONE);
      last_in   = (cmd.emit == EMIT_DIGIT) && status.cnt_one;
      case (cmd.emit)
         EMIT_DIGIT: char_in = digit_char(digs_ff[0], upper_ff);
         EMIT_MINUS: char_in = CHAR_MINUS;
         EMIT_ZERO:  char_in = CHAR_ZERO;
         EMIT_X:     char_in = CHAR_X;
         default:    char_in = char_ff;
      endcase
   end

   // Payload registers
   always_ff @(posedge clock) begin
      digs_ff  <= digs_in;
      cnt_ff   <= cnt_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      upper_ff <= upper_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign status.neg      = neg_ff;
   assign status.top_zero = (digs_ff[0] == 4'h0);
   assign status.cnt_one  = (cnt_ff == CNT_BITS'(1));

   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_strobe    = strobe_ff;

endmodule

// ===== sv/i2a_ctrl.sv =====
// Controller: sequences load, BCD conversion, leading-zero skip and character output.
module i2a_ctrl
   import i2a_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [2:0]    req_mode,
   input  logic          req_wide,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   localparam int ITER_BITS = $clog2(WORD_BITS + 1);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_CONV = 7'b0000010,
      ST_SIGN = 7'b0000100,
      ST_SKIP = 7'b0001000,
      ST_PFX0 = 7'b0010000,
      ST_PFX1 = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;

   // Next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      iter_in    = iter_ff;
      cmd.load   = 1'b0;
      cmd.dabble = 1'b0;
      cmd.skip   = 1'b0;
      cmd.emit   = EMIT_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_mode) inside
                  MODE_SDEC, MODE_UDEC: begin
                     state_in = ST_CONV;
                     iter_in  = req_wide ? ITER_BITS'(WORD_BITS) : ITER_BITS'(NARROW_BITS);
                  end
                  MODE_HEXL, MODE_HEXU, MODE_OCT: state_in = ST_SKIP;
                  MODE_PTR: state_in = ST_PFX0;
                  default:  state_in = ST_IDLE;   // undefined modes print nothing
               endcase
            end
         end
         ST_CONV: begin
            cmd.dabble = 1'b1;
            iter_in    = iter_ff - ITER_BITS'(1);
            if (iter_ff == ITER_BITS'(1)) begin
               state_in = status.neg ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            cmd.emit = EMIT_MINUS;
            state_in = ST_SKIP;
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (status.top_zero && !status.cnt_one) begin
               cmd.skip = 1'b1;
            end else begin
               cmd.emit = EMIT_DIGIT;
               state_in = status.cnt_one ? ST_IDLE : ST_EMIT;
            end
         end
         ST_PFX0: begin
            cmd.emit = EMIT_ZERO;
            state_in = ST_PFX1;
         end
         ST_PFX1: begin
            cmd.emit = EMIT_X;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = EMIT_DIGIT;
            if (status.cnt_one) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/integer_to_ascii_formatter_unit.sv =====
// Top level of the integer to ASCII formatter: controller plus datapath.
//
// A number is taken when start is high and busy is low; its characters then
// come out most significant first, one word per strobed cycle on
// rsp_char_code, with rsp_last on the final one. The receiver cannot stall:
// each word is valid for exactly one cycle after rsp_strobe rises and must be
// captured then. Decimal modes shift each operand bit through the
// shift-add-3 BCD converter (32 bits narrow, WORD_BITS wide), then emit
// a minus sign if negative, drop leading zeros and emit one word per digit.
// Hex and octal skip the converter and step through each digit position
// (16 or 22 at 64 bits); pointer mode emits 0 and x, then ceil(WORD_BITS/4)
// digits. Undefined modes print nothing. The last word is on the ports in
// the first cycle with busy low, so a new number may be started while it
// is there.
module integer_to_ascii_formatter_unit
   import i2a_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   input  logic [2:0]  req_mode,
   input  logic        req_wide,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last,
   output logic        rsp_strobe
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer
   i2a_ctrl #(
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .req_wide (req_wide),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Conversion datapath
   i2a_dpath #(
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .req_mode      (req_mode),
      .req_wide      (req_wide),
      .cmd           (cmd),
      .status        (status),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .rsp_strobe    (rsp_strobe)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the integer to ASCII formatter: text predictor, bursty driver, word checker.
module tb
   import i2a_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Codes with no name in the package: the block prints nothing for them
   localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
   localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

   localparam int PTR_WIDTH     = WORD_BITS_DEF;
   localparam int PTR_DIGITS    = (PTR_WIDTH + 3) / 4;
   localparam int RANDOM_COUNT  = 200;
   localparam int STALL_LIMIT   = 4000;   // cycles with neither a number nor a word taken
   localparam int SETTLE_CYCLES = 120;

   // Digit glyphs, first character in the top byte
   localparam logic [8*16-1:0] LOWER_GLYPHS = "0123456789abcdef";
   localparam logic [8*16-1:0] UPPER_GLYPHS = "0123456789ABCDEF";

   typedef struct {
      logic [63:0] value;
      logic [2:0]  mode;
      logic        wide;
      bit          drain;   // hold off until all text so far has come out
   } number_req_type;

   typedef struct packed {
      logic [7:0] code;
      logic       fin;
   } text_char_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_value;
   logic [2:0]  req_mode;
   logic        req_wide;
   logic [7:0]  rsp_char_code;
   logic        rsp_last;
   logic        rsp_strobe;

   number_req_type pending_numbers[$];
   text_char_type  expected_text[$];
   bit             number_taken;
   bit             progress;
   int             idle_cycles;
   int             failures;
   int             gap_left;
   int             burst_left;

   integer_to_ascii_formatter_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_mode      (req_mode),
      .req_wide      (req_wide),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .rsp_strobe    (rsp_strobe)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [7:0] glyph(input logic [3:0] d, input logic upper);
      logic [8*16-1:0] set;
      set = upper ? UPPER_GLYPHS : LOWER_GLYPHS;
      return set[8*(15 - d) +: 8];
   endfunction

   function automatic void push_char(input logic [7:0] code, input logic fin);
      text_char_type c;
      c.code = code;
      c.fin  = fin;
      expected_text.push_back(c);
   endfunction

   // Work out the text of one number and queue it, most significant first
   function automatic void predict_text(input logic [63:0] value, input logic [2:0] mode,
                                        input logic wide);
      logic [63:0] mask;
      logic [63:0] mag;
      logic [63:0] radix;
      logic [7:0]  digit_buf [0:23];
      logic        upper;
      int          bits;
      int          n;
      int          i;
      bits  = wide ? PTR_WIDTH : NARROW_BITS;
      mask  = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
      mag   = value & mask;
      radix = 64'd10;
      upper = 1'b0;
      n     = 0;
      if (mode == MODE_PTR) begin
         push_char(CHAR_ZERO, 1'b0);
         push_char(CHAR_X, 1'b0);
         for (i = PTR_DIGITS; i > 0; i--)
            push_char(glyph(4'((value >> (4 * (i - 1))) & 64'hf), 1'b0), i == 1);
         return;
      end
      if (mode > MODE_PTR)
         return;
      case (mode)
         MODE_SDEC: begin
            if (mag[bits - 1]) begin
               push_char(CHAR_MINUS, 1'b0);
               mag = (-mag) & mask;
            end
         end
         MODE_UDEC: radix = 64'd10;
         MODE_HEXL: radix = 64'd16;
         MODE_HEXU: begin
            radix = 64'd16;
            upper = 1'b1;
         end
         default:   radix = 64'd8;
      endcase
      do begin
         digit_buf[n] = glyph(4'(mag % radix), upper);
         n++;
         mag = mag / radix;
      end while (mag != 0 && n < 24);
      while (n > 0) begin
         n--;
         push_char(digit_buf[n], n == 0);
      end
   endfunction

   task automatic add_number(input logic [63:0] value, input logic [2:0] mode,
                             input logic wide, input bit drain);
      number_req_type r;
      r.value = value;
      r.mode  = mode;
      r.wide  = wide;
      r.drain = drain;
      pending_numbers.push_back(r);
   endtask

   // Driver: numbers go out in bursts, fields change on the falling edge
   always @(negedge clock) begin
      if (!reset && (!start || number_taken)) begin
         number_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_numbers.size() == 0 ||
                      (pending_numbers[0].drain && expected_text.size() != 0)) begin
            start <= 1'b0;
         end else begin
            req_value <= pending_numbers[0].value;
            req_mode  <= pending_numbers[0].mode;
            req_wide  <= pending_numbers[0].wide;
            void'(pending_numbers.pop_front());
            start <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
            end
         end
      end
   end

   // Monitor: check each strobed word, then predict the text of a taken number
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         progress = 1'b0;
         if (rsp_strobe) begin
            progress = 1'b1;
            if (expected_text.size() == 0) begin
               $error("unexpected word: char_code %h last %b", rsp_char_code, rsp_last);
               failures++;
            end else begin
               if (rsp_char_code !== expected_text[0].code) begin
                  $error("char_code: expected %h, actual %h", expected_text[0].code,
                         rsp_char_code);
                  failures++;
               end
               if (rsp_last !== expected_text[0].fin) begin
                  $error("last: expected %b, actual %b", expected_text[0].fin, rsp_last);
                  failures++;
               end
               void'(expected_text.pop_front());
            end
         end
         if (start && !busy) begin
            progress     = 1'b1;
            number_taken = 1'b1;
            predict_text(req_value, req_mode, req_wide);
         end
         idle_cycles <= progress ? 0 : idle_cycles + 1;
      end
   end

   // Watchdog
   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      logic [63:0] v;
      logic [2:0]  m;
      int          i;
      reset        = 1'b1;
      start        = 1'b0;
      req_value    = '0;
      req_mode     = MODE_SDEC;
      req_wide     = 1'b0;
      number_taken = 1'b0;
      idle_cycles  = 0;
      failures     = 0;
      gap_left     = 0;
      burst_left   = 1;

      // Directed: zero in every mode, extremes, most negative values, undefined modes
      add_number(64'd0, MODE_SDEC, 1'b0, 1'b0);
      add_number(64'd0, MODE_UDEC, 1'b1, 1'b0);
      add_number(64'd0, MODE_HEXL, 1'b0, 1'b0);
      add_number(64'd0, MODE_HEXU, 1'b1, 1'b0);
      add_number(64'd0, MODE_OCT, 1'b0, 1'b0);
      add_number(64'd0, MODE_PTR, 1'b1, 1'b0);
      add_number(64'hFFFF_FFFF_8000_0000, MODE_SDEC, 1'b0, 1'b0);
      add_number(64'h8000_0000_0000_0000, MODE_SDEC, 1'b1, 1'b0);
      add_number(64'h7FFF_FFFF_FFFF_FFFF, MODE_SDEC, 1'b1, 1'b0);
      add_number('1, MODE_SDEC, 1'b0, 1'b0);
      add_number('1, MODE_UDEC, 1'b1, 1'b0);
      add_number('1, MODE_UDEC, 1'b0, 1'b0);
      add_number('1, MODE_HEXL, 1'b1, 1'b0);
      add_number(64'hDEAD_BEEF_CAFE_F00D, MODE_HEXU, 1'b1, 1'b0);
      add_number(64'h1234_5678_9ABC_DEF0, MODE_HEXL, 1'b0, 1'b0);
      add_number('1, MODE_OCT, 1'b1, 1'b0);
      add_number('1, MODE_OCT, 1'b0, 1'b0);
      add_number(64'h0123_4567_89AB_CDEF, MODE_PTR, 1'b0, 1'b1);
      add_number('1, MODE_PTR, 1'b1, 1'b0);
      add_number(64'h5555_AAAA_5555_AAAA, MODE_UNDEF_LO, 1'b1, 1'b0);
      add_number(64'hAAAA_5555_AAAA_5555, MODE_UNDEF_HI, 1'b0, 1'b0);
      add_number(64'd9, MODE_UDEC, 1'b0, 1'b0);
      add_number(64'd10, MODE_UDEC, 1'b0, 1'b0);
      add_number(64'h0000_0000_7FFF_FFFF, MODE_SDEC, 1'b0, 1'b0);
      add_number('1, MODE_SDEC, 1'b1, 1'b0);

      // Random: mixed magnitudes and signs, a few undefined-mode words as noise
      for (i = 0; i < RANDOM_COUNT; i++) begin
         if ($urandom_range(0, 19) == 0)
            add_number({$urandom, $urandom}, $urandom_range(0, 1) ? MODE_UNDEF_LO : MODE_UNDEF_HI,
                       1'($urandom_range(0, 1)), 1'b0);
         m = 3'($urandom_range(0, 5));
         v = {$urandom, $urandom};
         case ($urandom_range(0, 3))
            0: v = v >> $urandom_range(0, 63);
            1: v = -(v >> $urandom_range(0, 63));
            2: v = 64'($urandom_range(0, 20));
            default: ;
         endcase
         add_number(v, m, 1'($urandom_range(0, 1)), (i % 60) == 30);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_numbers.size() != 0 || start) @(posedge clock);
      while (expected_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== integer_to_ascii_formatter_unit.f =====
sv/i2a_pkg.sv
sv/i2a_dpath.sv
sv/i2a_ctrl.sv
sv/integer_to_ascii_formatter_unit.sv
tb/tb.sv
